@@ hdl/packet_buffer_drop_scheduler_macros.svh @@
// assertion macros shared by the packet buffer drop scheduler modules
`ifndef PACKET_BUFFER_DROP_SCHEDULER_MACROS_SVH
`define PACKET_BUFFER_DROP_SCHEDULER_MACROS_SVH

// same-cycle implication, checked out of reset
`define PBDS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbds check failed");

// next-cycle implication, checked out of reset
`define PBDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbds check failed");

`endif

@@ hdl/pbds_pkg.sv @@
// shared types and field widths of the packet buffer drop scheduler
`default_nettype none
package pbds_pkg;

  localparam int ARR_W  = 32;
  localparam int PROC_W = 16;
  localparam int CFG_W  = 7;
  localparam logic [CFG_W-1:0] BUF_SIZE_RST = 7'd64;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;  // latch the incoming packet
    logic pop;   // retire the oldest held entry
    logic push;  // queue the finish time of the current packet
    logic emit;  // write the result register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic pop_ok;    // oldest entry finished at or before arrival
    logic full;      // buffer at capacity
    logic out_free;  // result register can take a beat this cycle
  } sts_t;

endpackage
`default_nettype wire

@@ hdl/pbds_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none
module pbds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ hdl/pbds_ctl.sv @@
// controller: sequences accept, retire loop and decision per packet
`default_nettype none
`include "packet_buffer_drop_scheduler_macros.svh"
module pbds_ctl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire pbds_pkg::sts_t sts,
  output pbds_pkg::cmd_t     cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_POP  = 1'b1;

  logic state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (sts.pop_ok) begin
          cmd.pop = 1'b1;
        end else if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.push  = !sts.full;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `PBDS_ASSERT_SAME(a_push_pop_excl, clk, rst_n, cmd.push, !cmd.pop)
  `PBDS_ASSERT_SAME(a_emit_needs_room, clk, rst_n, cmd.emit, sts.out_free)
  `PBDS_ASSERT_NEXT(a_load_to_pop, clk, rst_n, cmd.load, state_r == S_POP)

endmodule
`default_nettype wire

@@ hdl/pbds_dp.sv @@
// datapath: ring pointers, counters, finish-time math and result register
`default_nettype none
`include "packet_buffer_drop_scheduler_macros.svh"
module pbds_dp #(
  parameter int BUFFER_DEPTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [pbds_pkg::ARR_W-1:0]    pkt_arrival,
  input  wire logic [pbds_pkg::PROC_W-1:0]   pkt_ticks,
  input  wire logic                          cfg_wr_en,
  input  wire logic [pbds_pkg::CFG_W-1:0]    cfg_wr_data,
  input  wire pbds_pkg::cmd_t                cmd,
  output pbds_pkg::sts_t                     sts,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_dropped,
  output logic [pbds_pkg::ARR_W-1:0]         out_start
);

  localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int CMP_W = (CNT_W > pbds_pkg::CFG_W) ? CNT_W : pbds_pkg::CFG_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);
  localparam logic [CMP_W-1:0] DEPTH_C  = CMP_W'(BUFFER_DEPTH);

  logic [PTR_W-1:0]               head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic [pbds_pkg::ARR_W-1:0]     last_r, last_nxt;
  logic [pbds_pkg::ARR_W-1:0]     arr_r;
  logic [pbds_pkg::PROC_W-1:0]    proc_r;
  logic [pbds_pkg::CFG_W-1:0]     bsize_r;
  logic                           oval_r, oval_nxt;
  logic                           odrop_r;
  logic [pbds_pkg::ARR_W-1:0]     ostart_r;
  logic [pbds_pkg::ARR_W-1:0]     head_fin;
  logic [pbds_pkg::ARR_W-1:0]     start;
  logic [pbds_pkg::ARR_W:0]       fin_sum;
  logic [pbds_pkg::ARR_W-1:0]     fin;
  logic [CMP_W-1:0]               cap;
  logic [CMP_W-1:0]               count_ext;

  // capacity is the configured size clipped to the built depth
  assign cap = (CMP_W'(bsize_r) > DEPTH_C) ? DEPTH_C : CMP_W'(bsize_r);
  assign count_ext = CMP_W'(count_r);

  assign start   = ((count_r != '0) && (last_r > arr_r)) ? last_r : arr_r;
  assign fin_sum = {1'b0, start} + {{(pbds_pkg::ARR_W + 1 - pbds_pkg::PROC_W){1'b0}}, proc_r};
  assign fin     = fin_sum[pbds_pkg::ARR_W] ? '1 : fin_sum[pbds_pkg::ARR_W-1:0];

  assign sts.pop_ok   = (count_r != '0) && (head_fin <= arr_r);
  assign sts.full     = count_ext >= cap;
  assign sts.out_free = !oval_r || out_ready;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    last_nxt  = last_r;
    if (cmd.pop) begin
      head_nxt  = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
    if (cmd.push) begin
      tail_nxt  = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
      last_nxt  = fin;
    end
    oval_nxt = oval_r;
    if (cmd.emit) begin
      oval_nxt = 1'b1;
    end else if (out_ready) begin
      oval_nxt = 1'b0;
    end
  end

  // read address follows the next head so data tracks the pointer
  pbds_ram #(
    .WIDTH(pbds_pkg::ARR_W),
    .DEPTH(BUFFER_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (tail_r),
    .wr_data (fin),
    .rd_addr (head_nxt),
    .rd_data (head_fin)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      last_r  <= '0;
      bsize_r <= pbds_pkg::BUF_SIZE_RST;
      oval_r  <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      last_r  <= last_nxt;
      oval_r  <= oval_nxt;
      if (cfg_wr_en) begin
        bsize_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      arr_r  <= pkt_arrival;
      proc_r <= pkt_ticks;
    end
    if (cmd.emit) begin
      odrop_r  <= !cmd.push;
      ostart_r <= cmd.push ? start : '0;
    end
  end

  assign out_valid   = oval_r;
  assign out_dropped = odrop_r;
  assign out_start   = ostart_r;

  `PBDS_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, CMP_W'(count_r) <= DEPTH_C)
  `PBDS_ASSERT_SAME(a_empty_ptrs, clk, rst_n, count_r == '0, head_r == tail_r)
  `PBDS_ASSERT_NEXT(a_pop_count, clk, rst_n, cmd.pop, count_r == $past(count_r) - 1'b1)

endmodule
`default_nettype wire

@@ hdl/packet_buffer_drop_scheduler.sv @@
// packet buffer drop scheduler: one processor fronted by a bounded fifo of finish times
// sequence: accept in idle, then retire finished entries one per cycle, then decide once
//   the result register is free; the result beat shows in the cycle after the decision
// a new packet is taken only after the last one is decided; the single ring read port
//   retires one finished entry a cycle; each packet retires at most one entry on average
// reset: sync active-low rst_n empties the buffer, zeroes last finish, sets buffer_size
//   to 64; ring contents are not cleared, only written entries are ever read
`default_nettype none
module packet_buffer_drop_scheduler #(
  parameter int BUFFER_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // packet beats in
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // [31:0] arrival tick, [47:32] service ticks
  // result beats out
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] start tick
  output logic             out_tuser,  // [0] dropped
  // buffer_size register
  input  wire logic        cfg_wr_en,
  input  wire logic [6:0]  cfg_wr_data
);

  pbds_pkg::cmd_t cmd;
  pbds_pkg::sts_t sts;

  // controller: idle waits for a beat, then loops retiring finished entries
  // until the head is still busy or the buffer is empty, then decides once the result register is free
  pbds_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: finish-time ring in ram, head/tail/count, and the result
  // register that lets the next packet enter while a result waits
  pbds_dp #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .pkt_arrival  (in_tdata[31:0]),
    .pkt_ticks    (in_tdata[47:32]),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_dropped  (out_tuser),
    .out_start    (out_tdata)
  );

endmodule
`default_nettype wire
